FILE: design/bsws_pkg.sv
// Package for the bounded stack with search: operation codes, controller states
// and the fixed widths of the request and result ports.
// No dependencies; the top level and the testbench use it by scoped names.
package bsws_pkg;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN
  } state_t;

endpackage

FILE: design/bsws_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the stack words; no dependencies.
module bsws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bounded_stack_with_search.sv
// Top level of the bounded stack with search: controller, count register and
// result registers around one word RAM. Depends on bsws_pkg and bsws_ram.
//
//   channel   | handshake             | ports
//   ----------+-----------------------+---------------------------------------
//   request   | start && !busy        | operation, value
//   result    | done (one-cycle pulse)| status, data, found_index, count,
//             |                       | is_empty, is_full
//   config    | cfg_write             | cfg_data (capacity)
//
// Push, clear, unused codes and any pop, peek or search on an empty stack
// return their result in the cycle after the transaction, and busy stays low.
// Pop and peek read the RAM on acceptance; ST_FETCH registers the word.
// Search compares at most count entries, starting at the bottom entry:
// the RAM read port delivers one entry per cycle, compared as it arrives.
// Reset clears the count, sets capacity to 64 and returns to idle; the RAM
// needs no clearing pass since only entries below the count are ever reported.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bounded_stack_with_search #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bsws_pkg::OP_W-1:0]            operation,
  input  logic signed [bsws_pkg::VALUE_W-1:0]  value,
  input  logic                                 cfg_write,
  input  logic [bsws_pkg::COUNT_W-1:0]         cfg_data,
  output logic                                 done,
  output logic                                 status,
  output logic signed [bsws_pkg::VALUE_W-1:0]  data,
  output logic [bsws_pkg::INDEX_W-1:0]         found_index,
  output logic [bsws_pkg::COUNT_W-1:0]         count,
  output logic                                 is_empty,
  output logic                                 is_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  // Width wide enough to compare the count against the capacity register.
  localparam int KW = (CW > bsws_pkg::COUNT_W) ? CW : bsws_pkg::COUNT_W;

  // Control and result registers.
  bsws_pkg::state_t state, state_next;
  logic [CW-1:0]                   depth_count, depth_count_next;
  logic [bsws_pkg::COUNT_W-1:0]    capacity;
  logic [WORD_WIDTH-1:0]           key, key_next;
  logic [AW-1:0]                   cmp_idx, cmp_idx_next;
  logic                            done_next, status_next;
  logic [bsws_pkg::VALUE_W-1:0]    data_next;
  logic [bsws_pkg::INDEX_W-1:0]    index_next;

  // RAM port signals.
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata;

  // Derived values.
  logic                  accept;
  logic [KW-1:0]         eff_cap, count_ext;
  logic                  push_ok, has_entries, scan_match, scan_last;
  logic [63:0]           value_ext, rdata_ext;

  bsws_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = (state != bsws_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Clamp capacity to the storage depth.
  assign eff_cap   = (KW'(capacity) > KW'(DEPTH)) ? KW'(DEPTH) : KW'(capacity);
  assign count_ext = KW'(depth_count);
  // eff_cap never exceeds DEPTH, so this also keeps the write inside the RAM.
  assign push_ok     = count_ext < eff_cap;
  assign has_entries = (depth_count != '0);

  // Stored words are the low bits of the sign-extended request value; words
  // read back are sign-extended from the stored width and trimmed to 32 bits.
  assign value_ext  = 64'(value);
  assign mem_wdata  = value_ext[WORD_WIDTH-1:0];
  assign rdata_ext  = 64'($signed(mem_rdata));

  assign scan_match = (mem_rdata == key);
  assign scan_last  = ((CW'(cmp_idx) + CW'(1)) == depth_count);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bsws_pkg::ST_IDLE: begin
        if (accept) begin
          if ((operation == bsws_pkg::OP_POP || operation == bsws_pkg::OP_PEEK)
              && has_entries) begin
            state_next = bsws_pkg::ST_FETCH;
          end else if (operation == bsws_pkg::OP_SEARCH && has_entries) begin
            state_next = bsws_pkg::ST_SCAN;
          end
        end
      end
      bsws_pkg::ST_FETCH: begin
        state_next = bsws_pkg::ST_IDLE;
      end
      bsws_pkg::ST_SCAN: begin
        if (scan_match || scan_last) begin
          state_next = bsws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bsws_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath controls and result values.
  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = AW'(depth_count);
    mem_raddr        = AW'(depth_count - CW'(1));
    depth_count_next = depth_count;
    key_next         = key;
    cmp_idx_next     = cmp_idx;
    done_next        = 1'b0;
    status_next      = 1'b1;
    data_next        = '0;
    index_next       = '0;
    unique case (state)
      bsws_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (operation)
            bsws_pkg::OP_PUSH: begin
              done_next = 1'b1;
              if (push_ok) begin
                mem_we           = 1'b1;
                depth_count_next = depth_count + CW'(1);
                status_next      = 1'b0;
              end
            end
            bsws_pkg::OP_POP, bsws_pkg::OP_PEEK: begin
              // Read the top entry; the word is reported from ST_FETCH.
              if (has_entries) begin
                if (operation == bsws_pkg::OP_POP) begin
                  depth_count_next = depth_count - CW'(1);
                end
              end else begin
                done_next = 1'b1;
              end
            end
            bsws_pkg::OP_CLEAR: begin
              done_next        = 1'b1;
              depth_count_next = '0;
              status_next      = 1'b0;
            end
            bsws_pkg::OP_SEARCH: begin
              // Start the scan at the bottom entry.
              mem_raddr    = '0;
              key_next     = mem_wdata;
              cmp_idx_next = '0;
              if (!has_entries) begin
                done_next = 1'b1;
              end
            end
            default: begin
              // Unused code: report failure, leave the stack alone.
              done_next = 1'b1;
            end
          endcase
        end
      end
      bsws_pkg::ST_FETCH: begin
        done_next   = 1'b1;
        status_next = 1'b0;
        data_next   = rdata_ext[bsws_pkg::VALUE_W-1:0];
      end
      bsws_pkg::ST_SCAN: begin
        // Prefetch the next entry while comparing the current one.
        mem_raddr = cmp_idx + AW'(1);
        if (scan_match) begin
          done_next   = 1'b1;
          status_next = 1'b0;
          index_next  = bsws_pkg::INDEX_W'(cmp_idx);
        end else if (scan_last) begin
          done_next = 1'b1;
        end else begin
          cmp_idx_next = cmp_idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bsws_pkg::ST_IDLE;
      depth_count <= '0;
      capacity    <= bsws_pkg::COUNT_W'(64);
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      depth_count <= depth_count_next;
      done        <= done_next;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    key         <= key_next;
    cmp_idx     <= cmp_idx_next;
    status      <= status_next;
    data        <= data_next;
    found_index <= index_next;
  end

  // Count and flags come straight from the count register, which already
  // holds the value after the reported transaction while done is high.
  assign count    = bsws_pkg::COUNT_W'(depth_count);
  assign is_empty = !has_entries;
  assign is_full  = (count_ext >= eff_cap);

  // The count never grows past the storage depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    depth_count <= CW'(DEPTH))
    else $error("stack count exceeds storage depth");

  // A fetch always reports its word in the next cycle.
  a_fetch_done: assert property (@(posedge clk) disable iff (rst)
    state == bsws_pkg::ST_FETCH |=> done && !status)
    else $error("fetch did not complete");

  // A push that fits raises the count by exactly one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    accept && operation == bsws_pkg::OP_PUSH && push_ok
    |=> depth_count == $past(depth_count) + CW'(1))
    else $error("push did not advance the count");

  // Results only appear once the controller is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

endmodule

FILE: tb/sv/tb_bounded_stack_with_search.sv
// Self-checking testbench for bounded_stack_with_search: a clocked driver and
// monitor around a cycle-free stack predictor and a queue of expected results.
// Depends on bsws_pkg and the design sources only.
module tb_bounded_stack_with_search;

  localparam int STORE_DEPTH = 64;
  localparam int CAP_MAX     = 127;      // largest value the 7-bit register holds
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int TARGET_REQS = 1650;

  // Codes the block does not decode: it must answer them with a failure.
  localparam logic [bsws_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [bsws_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic [bsws_pkg::OP_W-1:0]           op;
    logic signed [bsws_pkg::VALUE_W-1:0] value;
  } stack_request_t;

  typedef struct {
    logic                                status;
    logic signed [bsws_pkg::VALUE_W-1:0] data;
    logic [bsws_pkg::INDEX_W-1:0]        found_index;
    logic [bsws_pkg::COUNT_W-1:0]        count;
    logic                                is_empty;
    logic                                is_full;
  } stack_reply_t;

  // Every input starts at a known value; reset is held from time zero.
  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic [bsws_pkg::OP_W-1:0]           operation = '0;
  logic signed [bsws_pkg::VALUE_W-1:0] value = '0;
  logic                                cfg_write = 1'b0;
  logic [bsws_pkg::COUNT_W-1:0]        cfg_data = '0;
  logic                                busy;
  logic                                done;
  logic                                status;
  logic signed [bsws_pkg::VALUE_W-1:0] data;
  logic [bsws_pkg::INDEX_W-1:0]        found_index;
  logic [bsws_pkg::COUNT_W-1:0]        count;
  logic                                is_empty;
  logic                                is_full;

  bounded_stack_with_search dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value       (value),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .done        (done),
    .status      (status),
    .data        (data),
    .found_index (found_index),
    .count       (count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Pending requests (filled by the sequencer) and results still owed by the block.
  stack_request_t request_q[$];
  stack_reply_t   stack_replies_q[$];

  // Predictor copy of the stack and its capacity register.
  logic [bsws_pkg::VALUE_W-1:0] model_words [STORE_DEPTH];
  int                           model_depth = 0;
  int                           model_cap = 64;

  int error_count = 0;
  int cycle_count = 0;
  int items_queued = 0;
  int results_checked = 0;

  // Coverage tallies for the closing summary.
  int n_push_ok = 0, n_push_refused = 0, n_reads_ok = 0, n_reads_empty = 0;
  int n_search_hit = 0, n_search_miss = 0, n_clears = 0, n_unused = 0;
  int peak_depth = 0;

  // Stimulus value pool, refreshed per phase so pushes and searches collide.
  logic signed [bsws_pkg::VALUE_W-1:0] value_pool [16];

  // Driver burst shaping.
  int             burst_left = 4;
  int             gap_left = 0;
  stack_request_t next_req;
  stack_reply_t   want;

  task automatic report_mismatch(input string msg);
    $display("[cycle %0d] MISMATCH: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                results_checked, name, got, exp_val));
  endtask

  // Compute the one result an accepted request produces, and advance the stack.
  function automatic void predict_reply(input logic [bsws_pkg::OP_W-1:0] op,
                                        input logic signed [bsws_pkg::VALUE_W-1:0] val);
    stack_reply_t r;
    int           eff_cap;
    bit           hit;
    eff_cap = (model_cap > STORE_DEPTH) ? STORE_DEPTH : model_cap;
    r.status = 1'b1;
    r.data = '0;
    r.found_index = '0;
    hit = 1'b0;
    case (op)
      bsws_pkg::OP_PUSH: begin
        if (model_depth < eff_cap) begin
          model_words[model_depth] = val;
          model_depth++;
          r.status = 1'b0;
          n_push_ok++;
        end else begin
          n_push_refused++;
        end
      end
      bsws_pkg::OP_POP, bsws_pkg::OP_PEEK: begin
        if (model_depth > 0) begin
          r.data = model_words[model_depth-1];
          if (op == bsws_pkg::OP_POP) model_depth--;
          r.status = 1'b0;
          n_reads_ok++;
        end else begin
          n_reads_empty++;
        end
      end
      bsws_pkg::OP_CLEAR: begin
        model_depth = 0;
        r.status = 1'b0;
        n_clears++;
      end
      bsws_pkg::OP_SEARCH: begin
        // Scan from the bottom; the lowest matching slot wins.
        for (int i = 0; i < model_depth; i++) begin
          if (!hit && model_words[i] == val) begin
            hit = 1'b1;
            r.found_index = i[bsws_pkg::INDEX_W-1:0];
            r.status = 1'b0;
          end
        end
        if (hit) n_search_hit++;
        else n_search_miss++;
      end
      default: n_unused++;
    endcase
    r.count = model_depth[bsws_pkg::COUNT_W-1:0];
    r.is_empty = (model_depth == 0);
    r.is_full = (model_depth >= eff_cap);
    if (model_depth > peak_depth) peak_depth = model_depth;
    stack_replies_q.push_back(r);
  endfunction

  // Driver: offer requests in bursts with random gaps; hold while busy.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // A transaction completes at this edge: predict its result now.
      if (start && !busy) predict_reply(operation, value);
      if (!start || !busy) begin
        if (gap_left == 0 && request_q.size() > 0) begin
          next_req = request_q.pop_front();
          start <= 1'b1;
          operation <= next_req.op;
          value <= next_req.value;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            // Some bursts run straight into the next one with no idle cycle.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done pulse must match the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (stack_replies_q.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = stack_replies_q.pop_front();
        check_field("status", status, want.status);
        check_field("data", data, want.data);
        check_field("found_index", found_index, want.found_index);
        check_field("count", count, want.count);
        check_field("is_empty", is_empty, want.is_empty);
        check_field("is_full", is_full, want.is_full);
        results_checked++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               stack_replies_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_request(input logic [bsws_pkg::OP_W-1:0] op,
                               input logic signed [bsws_pkg::VALUE_W-1:0] val);
    stack_request_t q;
    q.op = op;
    q.value = val;
    request_q.push_back(q);
    items_queued++;
  endtask

  // Hold until every queued request went through and every result came back.
  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || start || busy || stack_replies_q.size() != 0);
  endtask

  // Write the capacity register only when the block is quiet.
  task automatic set_capacity(input int cap);
    wait_idle();
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= cap[bsws_pkg::COUNT_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    model_cap = cap;
    @(negedge clk);
  endtask

  function automatic logic signed [bsws_pkg::VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return value_pool[$urandom_range(0, 15)];
    if (sel == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Queue a phase of random requests; weights steer the stack toward full or empty.
  task automatic queue_random_requests(input int n, input int push_pct, input int pop_pct);
    int r;
    int rest;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        queue_request(bsws_pkg::OP_PUSH, pick_value());
      end else if (r < push_pct + pop_pct) begin
        queue_request(($urandom_range(0, 3) == 0) ? bsws_pkg::OP_PEEK : bsws_pkg::OP_POP,
                      $urandom);
      end else begin
        rest = $urandom_range(0, 19);
        if (rest == 0) queue_request(bsws_pkg::OP_CLEAR, $urandom);
        else if (rest == 1)
          queue_request(bsws_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                        $urandom);
        else queue_request(bsws_pkg::OP_SEARCH, pick_value());
      end
    end
  endtask

  initial begin
    int cap;
    int n;
    int push_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-stack reads, extreme words, duplicates, unused codes, clear.
    queue_request(bsws_pkg::OP_POP, 32'sh0);
    queue_request(bsws_pkg::OP_PEEK, 32'sh0);
    queue_request(bsws_pkg::OP_SEARCH, 32'sh0);
    queue_request(bsws_pkg::OP_PUSH, 32'sh8000_0000);
    queue_request(bsws_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    queue_request(bsws_pkg::OP_PUSH, 32'sh0);
    queue_request(bsws_pkg::OP_PUSH, -32'sd1);
    queue_request(bsws_pkg::OP_PUSH, 32'sh5A5A_A5A5);
    queue_request(bsws_pkg::OP_PEEK, 32'sh0);
    queue_request(bsws_pkg::OP_SEARCH, -32'sd1);
    queue_request(bsws_pkg::OP_SEARCH, 32'sh8000_0000);
    queue_request(bsws_pkg::OP_SEARCH, 32'sh1234_5678);
    queue_request(bsws_pkg::OP_PUSH, -32'sd1);
    queue_request(bsws_pkg::OP_SEARCH, -32'sd1);       // duplicate: lower slot must win
    queue_request(bsws_pkg::OP_POP, 32'sh0);
    queue_request(bsws_pkg::OP_POP, 32'sh0);
    queue_request(OP_UNUSED_FIRST, 32'sh7FFF_FFFF);
    queue_request(OP_UNUSED_FIRST + 3'd1, -32'sd1);
    queue_request(OP_UNUSED_LAST, 32'sh0);
    queue_request(bsws_pkg::OP_CLEAR, 32'sh0);
    queue_request(bsws_pkg::OP_POP, 32'sh0);
    queue_request(bsws_pkg::OP_SEARCH, 32'sh0);

    // Capacity zero: every push is refused and the stack reads as full.
    set_capacity(0);
    queue_random_requests(40, 50, 20);
    // Capacity one: toggles between empty and full.
    set_capacity(1);
    queue_random_requests(60, 45, 30);
    // Register above storage depth: the block saturates at 64 entries.
    set_capacity(CAP_MAX);
    queue_random_requests(160, 80, 5);
    // Lower the limit below the held count: entries stay, pushes refused.
    set_capacity(12);
    queue_random_requests(100, 30, 40);
    set_capacity(STORE_DEPTH);
    queue_random_requests(200, 60, 15);
    set_capacity(STORE_DEPTH + 1);
    queue_random_requests(150, 20, 55);

    // Random settings until the target count is reached.
    while (items_queued < TARGET_REQS) begin
      case ($urandom_range(0, 7))
        0: cap = 0;
        1: cap = $urandom_range(STORE_DEPTH, CAP_MAX);
        2: cap = $urandom_range(1, 4);
        default: cap = $urandom_range(1, STORE_DEPTH);
      endcase
      n = $urandom_range(40, 120);
      push_pct = $urandom_range(30, 75);
      set_capacity(cap);
      queue_random_requests(n, push_pct, $urandom_range(10, 95 - push_pct));
    end

    // Drain: allow a bounded wait for the last results, then settle.
    for (int w = 0; w < DRAIN_LIMIT; w++) begin
      @(negedge clk);
      if (request_q.size() == 0 && !start && !busy && stack_replies_q.size() == 0)
        break;
    end
    repeat (10) @(negedge clk);
    if (stack_replies_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                stack_replies_q.size()));

    $display("covered %0d requests: %0d pushes stored, %0d refused, %0d reads, %0d on empty",
             items_queued, n_push_ok, n_push_refused, n_reads_ok, n_reads_empty);
    $display("searches %0d hit / %0d miss, %0d clears, %0d unused codes, peak depth %0d",
             n_search_hit, n_search_miss, n_clears, n_unused, peak_depth);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
design/bsws_pkg.sv
design/bsws_ram.sv
design/bounded_stack_with_search.sv
tb/sv/tb_bounded_stack_with_search.sv
